// ----- hw/rtl/srarq_pkg.sv -----
// Shared types, codes and helpers for the selective-repeat ARQ engine.
package srarq_pkg;

    localparam int SEQ_W        = 4;
    localparam int SLOT_W       = 3;
    localparam int LEN_W        = 9;
    localparam int CNT_W        = 4;
    localparam int WINDOW       = 8;
    localparam int PACKET_BYTES = 256;
    localparam int OVERHEAD     = 7;   // header plus CRC bytes

    localparam logic [2:0] ACT_PKT_READY = 3'd0;
    localparam logic [2:0] ACT_PHY_READY = 3'd1;
    localparam logic [2:0] ACT_FRAME     = 3'd2;
    localparam logic [2:0] ACT_DATA_TO   = 3'd3;
    localparam logic [2:0] ACT_ACK_TO    = 3'd4;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_NAK  = 2'd2;

    localparam logic [2:0] CMD_SEND    = 3'd0;
    localparam logic [2:0] CMD_NAK     = 3'd1;
    localparam logic [2:0] CMD_ACK     = 3'd2;
    localparam logic [2:0] CMD_RESTART = 3'd3;
    localparam logic [2:0] CMD_DELIVER = 3'd4;
    localparam logic [2:0] CMD_STOP    = 3'd5;
    localparam logic [2:0] CMD_STATUS  = 3'd6;

    typedef struct packed {
        logic [2:0]       action;
        logic [LEN_W-1:0] packet_len;
        logic             crc_good;
        logic [1:0]       rx_kind;
        logic [SEQ_W-1:0] frame_seq;
        logic [SEQ_W-1:0] rx_ack;
        logic [LEN_W-1:0] rx_bytes;
        logic [SEQ_W-1:0] expired_seq;
    } arq_in_t;

    typedef struct packed {
        logic [2:0]        command;
        logic [SEQ_W-1:0]  seq_out;
        logic [SEQ_W-1:0]  ack_out;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  length_out;
        logic              net_enable;
        logic              last;
    } arq_out_t;

    typedef enum logic [3:0] {
        EV_NONE,
        EV_SEND,
        EV_LINK,
        EV_RX_BAD,
        EV_RX_DATA,
        EV_RX_NAK,
        EV_RX_ACK,
        EV_TIMEOUT,
        EV_ACKTO
    } ev_class_t;

    typedef struct packed {
        ev_class_t        cls;
        logic [LEN_W-1:0] pkt_len;
        logic [SEQ_W-1:0] frame_seq;
        logic [SEQ_W-1:0] rx_ack;
        logic [LEN_W-1:0] rx_bytes;
        logic [SEQ_W-1:0] expired_seq;
    } arq_evt_t;

    // true when b lies in the circular range [a, c)
    function automatic logic in_window(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b,
                                       logic [SEQ_W-1:0] c);
        return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

endpackage

// ----- hw/rtl/srarq_front.sv -----
// Front end: accepts events, classifies them and queues them for the sequencer.
module srarq_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  srarq_pkg::arq_in_t item,
    output logic               q_valid,
    output srarq_pkg::arq_evt_t q_head,
    input  logic               q_pop
);

    srarq_pkg::arq_evt_t q_mem_reg [2];
    logic       head_reg, head_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    srarq_pkg::arq_evt_t evt;

    always_comb
    begin
        evt.pkt_len     = (item.packet_len > srarq_pkg::LEN_W'(srarq_pkg::PACKET_BYTES))
                          ? srarq_pkg::LEN_W'(srarq_pkg::PACKET_BYTES) : item.packet_len;
        evt.frame_seq   = item.frame_seq;
        evt.rx_ack      = item.rx_ack;
        evt.rx_bytes    = item.rx_bytes;
        evt.expired_seq = item.expired_seq;
        unique case (item.action)
            srarq_pkg::ACT_PKT_READY: evt.cls = srarq_pkg::EV_SEND;
            srarq_pkg::ACT_PHY_READY: evt.cls = srarq_pkg::EV_LINK;
            srarq_pkg::ACT_FRAME:
            begin
                if (!item.crc_good)
                    evt.cls = srarq_pkg::EV_RX_BAD;
                else if (item.rx_kind == srarq_pkg::KIND_DATA)
                    evt.cls = srarq_pkg::EV_RX_DATA;
                else if (item.rx_kind == srarq_pkg::KIND_NAK)
                    evt.cls = srarq_pkg::EV_RX_NAK;
                else
                    evt.cls = srarq_pkg::EV_RX_ACK;
            end
            srarq_pkg::ACT_DATA_TO:   evt.cls = srarq_pkg::EV_TIMEOUT;
            srarq_pkg::ACT_ACK_TO:    evt.cls = srarq_pkg::EV_ACKTO;
            default:                  evt.cls = srarq_pkg::EV_NONE;
        endcase
    end

    assign busy    = (cnt_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_head  = q_mem_reg[head_reg];

    always_comb
    begin
        head_next = head_reg;
        cnt_next  = cnt_reg;
        if (q_pop && q_valid)
        begin
            head_next = ~head_reg;
            cnt_next  = cnt_next - 2'd1;
        end
        if (push)
            cnt_next = cnt_next + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[head_reg ^ cnt_reg[0]] <= evt;
    end

endmodule

// ----- hw/rtl/srarq_back.sv -----
// Back end: window state and the command sequencer, which pops the next event only after finishing the last.
module srarq_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  srarq_pkg::arq_evt_t q_head,
    output logic                q_pop,
    output srarq_pkg::arq_out_t result,
    output logic                strobe
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_HEAD   = 6'b000010,
        S_DELIV  = 6'b000100,
        S_NAKRTX = 6'b001000,
        S_ACKW   = 6'b010000,
        S_STATUS = 6'b100000
    } state_t;

    localparam int SW = srarq_pkg::SEQ_W;
    localparam int LW = srarq_pkg::LEN_W;
    localparam int PW = srarq_pkg::SLOT_W;

    state_t state_reg, state_next;
    srarq_pkg::arq_evt_t ev_reg, ev_next;
    logic [SW-1:0] aes_reg, aes_next, nss_reg, nss_next;
    logic [SW-1:0] exp_reg, exp_next, wu_reg, wu_next;
    logic [srarq_pkg::CNT_W-1:0] outc_reg, outc_next;
    logic [srarq_pkg::WINDOW-1:0] arr_reg, arr_next;
    logic nak_ok_reg, nak_ok_next, link_reg, link_next;
    srarq_pkg::arq_out_t res_reg, res_next;
    logic strobe_reg, strobe_next;

    logic [LW-1:0] rx_len_mem [srarq_pkg::WINDOW];
    logic [LW-1:0] tx_len_mem [srarq_pkg::WINDOW];
    logic          rx_we, tx_we;
    logic [PW-1:0] rx_waddr, rx_raddr, tx_waddr, tx_raddr;
    logic [LW-1:0] rx_wdata, tx_wdata, dlen;
    logic [LW-1:0] tx_rdata_reg, rx_rdata_reg;
    logic [SW-1:0] ack_fld, want;

    assign ack_fld  = exp_reg - SW'(1);
    assign want     = ev_reg.rx_ack + SW'(1);
    // reads are registered: fetch for the state that follows
    assign tx_raddr = (state_reg == S_IDLE) ? q_head.expired_seq[PW-1:0] : want[PW-1:0];
    assign rx_raddr = exp_next[PW-1:0];

    always_comb
    begin
        if (rx_rdata_reg > LW'(srarq_pkg::OVERHEAD))
            dlen = rx_rdata_reg - LW'(srarq_pkg::OVERHEAD);
        else
            dlen = '0;
        if (dlen > LW'(srarq_pkg::PACKET_BYTES))
            dlen = LW'(srarq_pkg::PACKET_BYTES);
    end

    always_comb
    begin
        state_next  = state_reg;
        ev_next     = ev_reg;
        aes_next    = aes_reg;
        nss_next    = nss_reg;
        exp_next    = exp_reg;
        wu_next     = wu_reg;
        outc_next   = outc_reg;
        arr_next    = arr_reg;
        nak_ok_next = nak_ok_reg;
        link_next   = link_reg;
        res_next    = '0;
        strobe_next = 1'b0;
        q_pop       = 1'b0;
        rx_we       = 1'b0;
        tx_we       = 1'b0;
        rx_waddr    = ev_reg.frame_seq[PW-1:0];
        rx_wdata    = ev_reg.rx_bytes;
        tx_waddr    = nss_reg[PW-1:0];
        tx_wdata    = ev_reg.pkt_len;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    ev_next    = q_head;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                state_next = S_STATUS;
                unique case (ev_reg.cls)
                    srarq_pkg::EV_SEND:
                    begin
                        if (outc_reg < srarq_pkg::CNT_W'(srarq_pkg::WINDOW))
                        begin
                            tx_we       = 1'b1;
                            strobe_next = 1'b1;
                            res_next.command    = srarq_pkg::CMD_SEND;
                            res_next.seq_out    = nss_reg;
                            res_next.ack_out    = ack_fld;
                            res_next.slot       = nss_reg[PW-1:0];
                            res_next.length_out = ev_reg.pkt_len;
                            nss_next  = nss_reg + SW'(1);
                            outc_next = outc_reg + srarq_pkg::CNT_W'(1);
                        end
                    end
                    srarq_pkg::EV_LINK: link_next = 1'b1;
                    srarq_pkg::EV_TIMEOUT:
                    begin
                        strobe_next = 1'b1;
                        res_next.command    = srarq_pkg::CMD_SEND;
                        res_next.seq_out    = ev_reg.expired_seq;
                        res_next.ack_out    = ack_fld;
                        res_next.slot       = ev_reg.expired_seq[PW-1:0];
                        res_next.length_out = tx_rdata_reg;
                    end
                    srarq_pkg::EV_ACKTO:
                    begin
                        strobe_next = 1'b1;
                        res_next.command = srarq_pkg::CMD_ACK;
                        res_next.ack_out = ack_fld;
                    end
                    srarq_pkg::EV_RX_BAD:
                    begin
                        if (nak_ok_reg)
                        begin
                            strobe_next      = 1'b1;
                            res_next.command = srarq_pkg::CMD_NAK;
                            res_next.ack_out = ack_fld;
                            nak_ok_next      = 1'b0;
                        end
                    end
                    srarq_pkg::EV_RX_DATA:
                    begin
                        strobe_next = 1'b1;
                        if (ev_reg.frame_seq != exp_reg && nak_ok_reg)
                        begin
                            res_next.command = srarq_pkg::CMD_NAK;
                            res_next.ack_out = ack_fld;
                            nak_ok_next      = 1'b0;
                        end
                        else
                            res_next.command = srarq_pkg::CMD_RESTART;
                        if (srarq_pkg::in_window(exp_reg, ev_reg.frame_seq, wu_reg)
                            && !arr_reg[ev_reg.frame_seq[PW-1:0]])
                        begin
                            arr_next[ev_reg.frame_seq[PW-1:0]] = 1'b1;
                            rx_we      = 1'b1;
                            state_next = S_DELIV;
                        end
                        else
                            state_next = S_ACKW;
                    end
                    srarq_pkg::EV_RX_NAK: state_next = S_NAKRTX;
                    srarq_pkg::EV_RX_ACK: state_next = S_ACKW;
                    default: ;
                endcase
            end
            S_DELIV:
            begin
                if (arr_reg[exp_reg[PW-1:0]])
                begin
                    strobe_next         = 1'b1;
                    res_next.command    = srarq_pkg::CMD_DELIVER;
                    res_next.slot       = exp_reg[PW-1:0];
                    res_next.length_out = dlen;
                    nak_ok_next         = 1'b1;
                    arr_next[exp_reg[PW-1:0]] = 1'b0;
                    exp_next = exp_reg + SW'(1);
                    wu_next  = wu_reg + SW'(1);
                end
                else
                    state_next = S_ACKW;
            end
            S_NAKRTX:
            begin
                if (srarq_pkg::in_window(aes_reg, want, nss_reg))
                begin
                    strobe_next         = 1'b1;
                    res_next.command    = srarq_pkg::CMD_SEND;
                    res_next.seq_out    = want;
                    res_next.ack_out    = ack_fld;
                    res_next.slot       = want[PW-1:0];
                    res_next.length_out = tx_rdata_reg;
                end
                state_next = S_ACKW;
            end
            S_ACKW:
            begin
                if (srarq_pkg::in_window(aes_reg, ev_reg.rx_ack, nss_reg)
                    && outc_reg != '0)
                begin
                    strobe_next      = 1'b1;
                    res_next.command = srarq_pkg::CMD_STOP;
                    res_next.slot    = aes_reg[PW-1:0];
                    outc_next        = outc_reg - srarq_pkg::CNT_W'(1);
                    aes_next         = aes_reg + SW'(1);
                end
                else
                    state_next = S_STATUS;
            end
            S_STATUS:
            begin
                strobe_next         = 1'b1;
                res_next.command    = srarq_pkg::CMD_STATUS;
                res_next.net_enable = (outc_reg < srarq_pkg::CNT_W'(srarq_pkg::WINDOW))
                                      && link_reg;
                res_next.last       = 1'b1;
                state_next          = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            aes_reg    <= '0;
            nss_reg    <= '0;
            exp_reg    <= '0;
            wu_reg     <= SW'(srarq_pkg::WINDOW);
            outc_reg   <= '0;
            arr_reg    <= '0;
            nak_ok_reg <= 1'b1;
            link_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            aes_reg    <= aes_next;
            nss_reg    <= nss_next;
            exp_reg    <= exp_next;
            wu_reg     <= wu_next;
            outc_reg   <= outc_next;
            arr_reg    <= arr_next;
            nak_ok_reg <= nak_ok_next;
            link_reg   <= link_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg  <= ev_next;
        res_reg <= res_next;
        if (rx_we)
            rx_len_mem[rx_waddr] <= rx_wdata;
        if (tx_we)
            tx_len_mem[tx_waddr] <= tx_wdata;
        // a frame written into the slot about to be delivered is forwarded
        if (rx_we && rx_waddr == rx_raddr)
            rx_rdata_reg <= rx_wdata;
        else
            rx_rdata_reg <= rx_len_mem[rx_raddr];
        tx_rdata_reg <= tx_len_mem[tx_raddr];
    end

    assign result = res_reg;
    assign strobe = strobe_reg;

endmodule

// ----- hw/rtl/selective_repeat_arq_engine_top.sv -----
// Results follow one per cycle, with an idle gap between walk phases; an event
// holds the sequencer until its delivery and ack walks over the window are done.
// A two-entry event queue lets start be taken while the sequencer works. Reset
// clears windows, counters and arrived map. Results cannot be stalled: each
// shows for one cycle with strobe.
module selective_repeat_arq_engine_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  srarq_pkg::arq_in_t  item,
    output srarq_pkg::arq_out_t result,
    output logic                strobe
);

    logic                q_valid;
    logic                q_pop;
    srarq_pkg::arq_evt_t q_head;

    srarq_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    srarq_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .result  (result),
        .strobe  (strobe)
    );

endmodule

// ----- hw/rtl/srarq_checker.sv -----
// Port-level assertions for the ARQ engine, bound to the top level.
module srarq_checker (
    input logic                clk,
    input logic                rst_n,
    input srarq_pkg::arq_out_t result,
    input logic                strobe
);

    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last |-> result.command == srarq_pkg::CMD_STATUS)
        else $error("last result is not status");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.command == srarq_pkg::CMD_STATUS |-> result.last)
        else $error("status result without last");

    a_enable_only_status: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.command != srarq_pkg::CMD_STATUS |-> !result.net_enable)
        else $error("net_enable on non-status result");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last |=> !strobe)
        else $error("result directly after status");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> result.length_out <= srarq_pkg::LEN_W'(srarq_pkg::PACKET_BYTES))
        else $error("length above packet size");

endmodule

bind selective_repeat_arq_engine_top srarq_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .result (result),
    .strobe (strobe)
);

// ----- dv/selective_repeat_arq_engine_top_tb.sv -----
// Self-checking testbench for the selective-repeat ARQ window engine.
module selective_repeat_arq_engine_top_tb;
    import srarq_pkg::*;

    localparam int SEQ_TOP   = 15;
    localparam int CYCLE_CAP = 400000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    arq_in_t  item;
    arq_out_t result;
    logic     strobe;

    selective_repeat_arq_engine_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .result (result),
        .strobe (strobe)
    );

    // predicted window state
    logic [3:0] p_ack_exp;
    logic [3:0] p_next_seq;
    logic [3:0] p_rx_exp;
    logic [3:0] p_rx_upper;
    int         p_outstanding;
    logic [7:0] p_arrived;
    logic [8:0] p_rx_len [8];
    logic [8:0] p_tx_len [8];
    logic       p_nak_ok;
    logic       p_link;
    logic [7:0] p_tx_written;

    arq_out_t pending_cmds[$];
    int       mismatches = 0;
    int       cycle_count = 0;
    int       send_idle_pct = 0;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [3:0] seq_next(logic [3:0] k);
        return (k < SEQ_TOP) ? k + 4'd1 : 4'd0;
    endfunction

    function automatic logic circ_between(logic [3:0] a, logic [3:0] b, logic [3:0] c);
        return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

    function automatic arq_out_t mk_cmd(logic [2:0] c, logic [3:0] s, logic [3:0] a,
                                        logic [2:0] sl, logic [8:0] l);
        arq_out_t r;
        r.command    = c;
        r.seq_out    = s;
        r.ack_out    = a;
        r.slot       = sl;
        r.length_out = l;
        r.net_enable = 1'b0;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic void push_send(logic [3:0] s);
        pending_cmds.push_back(mk_cmd(CMD_SEND, s, p_rx_exp - 4'd1, s[2:0], p_tx_len[s[2:0]]));
    endfunction

    function automatic void push_nak();
        pending_cmds.push_back(mk_cmd(CMD_NAK, 4'd0, p_rx_exp - 4'd1, 3'd0, 9'd0));
        p_nak_ok = 1'b0;
    endfunction

    // advance the window state for one event and queue the commands it emits
    function automatic void predict_event(arq_in_t ev);
        arq_out_t   st;
        logic [3:0] want;
        logic [2:0] sl;
        logic [8:0] dl;
        case (ev.action)
            ACT_PKT_READY:
            begin
                if (p_outstanding < WINDOW)
                begin
                    p_tx_len[p_next_seq[2:0]] = (ev.packet_len > PACKET_BYTES) ?
                                                 9'(PACKET_BYTES) : ev.packet_len;
                    p_tx_written[p_next_seq[2:0]] = 1'b1;
                    push_send(p_next_seq);
                    p_next_seq = seq_next(p_next_seq);
                    p_outstanding++;
                end
            end
            ACT_PHY_READY: p_link = 1'b1;
            ACT_FRAME:
            begin
                if (!ev.crc_good)
                begin
                    if (p_nak_ok)
                        push_nak();
                end
                else
                begin
                    if (ev.rx_kind == KIND_DATA)
                    begin
                        if (ev.frame_seq != p_rx_exp && p_nak_ok)
                            push_nak();
                        else
                            pending_cmds.push_back(mk_cmd(CMD_RESTART, '0, '0, '0, '0));
                        if (circ_between(p_rx_exp, ev.frame_seq, p_rx_upper) &&
                            !p_arrived[ev.frame_seq[2:0]])
                        begin
                            p_arrived[ev.frame_seq[2:0]] = 1'b1;
                            p_rx_len[ev.frame_seq[2:0]] = ev.rx_bytes;
                            while (p_arrived[p_rx_exp[2:0]])
                            begin
                                sl = p_rx_exp[2:0];
                                dl = (p_rx_len[sl] > 9'(OVERHEAD)) ?
                                     p_rx_len[sl] - 9'(OVERHEAD) : 9'd0;
                                if (dl > 9'(PACKET_BYTES))
                                    dl = 9'(PACKET_BYTES);
                                pending_cmds.push_back(mk_cmd(CMD_DELIVER, '0, '0, sl, dl));
                                p_nak_ok = 1'b1;
                                p_arrived[sl] = 1'b0;
                                p_rx_exp = seq_next(p_rx_exp);
                                p_rx_upper = seq_next(p_rx_upper);
                            end
                        end
                    end
                    if (ev.rx_kind == KIND_NAK)
                    begin
                        want = ev.rx_ack + 4'd1;
                        if (circ_between(p_ack_exp, want, p_next_seq))
                            push_send(want);
                    end
                    while (circ_between(p_ack_exp, ev.rx_ack, p_next_seq) &&
                           p_outstanding > 0)
                    begin
                        p_outstanding--;
                        pending_cmds.push_back(mk_cmd(CMD_STOP, '0, '0, p_ack_exp[2:0], '0));
                        p_ack_exp = seq_next(p_ack_exp);
                    end
                end
            end
            ACT_DATA_TO: push_send(ev.expired_seq);
            ACT_ACK_TO:
                pending_cmds.push_back(mk_cmd(CMD_ACK, '0, p_rx_exp - 4'd1, '0, '0));
            default: ;
        endcase
        st = mk_cmd(CMD_STATUS, '0, '0, '0, '0);
        st.net_enable = (p_outstanding < WINDOW) && p_link;
        st.last = 1'b1;
        pending_cmds.push_back(st);
    endfunction

    always @(posedge clk)
    begin
        arq_out_t exp_cmd;
        if (rst_n && strobe)
        begin
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                exp_cmd = pending_cmds.pop_front();
                if (result !== exp_cmd)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_cmd, result);
                end
            end
        end
    end

    // one transfer; prediction runs after the accepting edge, once busy is low
    task automatic send_event(arq_in_t ev);
        while (($urandom_range(99) < send_idle_pct))
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= ev;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_event(ev);
    endtask

    function automatic arq_in_t blank_event(logic [2:0] act);
        arq_in_t ev;
        ev = '0;
        ev.action = act;
        ev.crc_good = 1'b1;
        return ev;
    endfunction

    task automatic drain();
        start <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic test_directed();
        arq_in_t ev;
        send_event(blank_event(ACT_ACK_TO));
        send_event(blank_event(ACT_PHY_READY));
        ev = blank_event(ACT_PKT_READY); ev.packet_len = 9'h1FF; send_event(ev);
        ev.packet_len = 9'd0; send_event(ev);
        ev.packet_len = 9'd256; send_event(ev);
        ev = blank_event(ACT_DATA_TO); ev.expired_seq = 4'd1; send_event(ev);
        ev = blank_event(ACT_FRAME); ev.crc_good = 1'b0; send_event(ev);
        send_event(ev);
        ev = blank_event(ACT_FRAME); ev.frame_seq = 4'd1; ev.rx_bytes = 9'd3; send_event(ev);
        ev.frame_seq = 4'd0; ev.rx_bytes = 9'h1FF; ev.rx_ack = 4'd15; send_event(ev);
        ev = blank_event(ACT_FRAME); ev.rx_kind = KIND_NAK; ev.rx_ack = 4'd0;
        send_event(ev);
        ev = blank_event(ACT_FRAME); ev.rx_kind = 2'd3; ev.rx_ack = 4'd2; send_event(ev);
        ev = blank_event(3'd5); send_event(ev);
        ev = blank_event(3'd7); ev.packet_len = 9'h1FF; send_event(ev);
        repeat (9)
        begin
            ev = blank_event(ACT_PKT_READY); ev.packet_len = 9'd100; send_event(ev);
        end
        drain();
    endtask

    task automatic test_random(int n_events, int idle_pct);
        arq_in_t    ev;
        int         pick;
        logic [3:0] span;
        send_idle_pct = idle_pct;
        repeat (n_events)
        begin
            ev = arq_in_t'({$urandom, $urandom});
            pick = $urandom_range(99);
            span = p_next_seq - p_ack_exp;
            if (pick < 30)
            begin
                ev.action = ACT_PKT_READY;
                ev.packet_len = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(256));
            end
            else if (pick < 72)
            begin
                ev.action = ACT_FRAME;
                ev.crc_good = ($urandom_range(9) != 0);
                ev.rx_kind = 2'($urandom_range(3));
                // mostly plausible sequence and ack numbers
                if ($urandom_range(3) != 0)
                    ev.frame_seq = p_rx_exp + 4'($urandom_range(7));
                if ($urandom_range(3) != 0)
                    ev.rx_ack = p_ack_exp + 4'($urandom_range(span)) - 4'd1;
                if (ev.rx_kind == KIND_NAK && span != 0)
                    ev.rx_ack = p_ack_exp + 4'($urandom_range(span - 1)) - 4'd1;
                ev.rx_bytes = ($urandom_range(4) == 0) ? 9'($urandom) : 9'($urandom_range(263));
            end
            else if (pick < 82)
            begin
                ev.action = ACT_DATA_TO;
                ev.expired_seq = p_ack_exp + 4'($urandom_range(span == 0 ? 0 : span - 1));
                if (!p_tx_written[ev.expired_seq[2:0]])
                    ev.action = ACT_ACK_TO;
            end
            else if (pick < 92)
                ev.action = ACT_ACK_TO;
            else if (pick < 96)
                ev.action = ACT_PHY_READY;
            else
                ev.action = 3'($urandom_range(7, 5));
            // retransmit requests must hit written slots
            if (ev.action == ACT_FRAME && ev.crc_good && ev.rx_kind == KIND_NAK &&
                circ_between(p_ack_exp, ev.rx_ack + 4'd1, p_next_seq) &&
                !p_tx_written[3'(ev.rx_ack + 4'd1)])
                ev.rx_kind = KIND_DATA;
            send_event(ev);
            if ($urandom_range(40) == 0)
                drain();
        end
        drain();
    endtask

    initial begin
        rst_n <= 1'b0;
        start <= 1'b0;
        item  <= '0;
        p_ack_exp = 0;
        p_next_seq = 0;
        p_rx_exp = 0;
        p_rx_upper = 4'(WINDOW);
        p_outstanding = 0;
        p_arrived = '0;
        p_nak_ok = 1'b1;
        p_link = 1'b0;
        p_tx_written = '0;
        for (int i = 0; i < 8; i++)
        begin
            p_rx_len[i] = '0;
            p_tx_len[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(100, 24);
        test_random(100, 50);
        test_random(100, 0);
        drain();
        if (mismatches == 0 && pending_cmds.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/srarq_pkg.sv
hw/rtl/srarq_front.sv
hw/rtl/srarq_back.sv
hw/rtl/selective_repeat_arq_engine_top.sv
hw/rtl/srarq_checker.sv
dv/selective_repeat_arq_engine_top_tb.sv
